[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a fixed delay in cycles, checked outside reset.
`define ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

[hw/rtl/trte_pkg.sv]
// Types and constants for the tone request to timer event block.
package trte_pkg;

    localparam int unsigned DIV_STEPS = 16;
    // Front stage, one stage per quotient bit, output stage.
    localparam int unsigned LATENCY = DIV_STEPS + 2;

    // 1193181 = 0x12_34DD: upper bits seed the remainder, lower bits shift in.
    localparam logic [14:0] DIVIDEND_HI = 15'h0012;
    localparam logic [15:0] DIVIDEND_LO = 16'h34DD;
    // Frequencies at or below this give a quotient above 16 bits.
    localparam logic [14:0] SAT_FREQ    = 15'd18;
    localparam logic [14:0] TICK_LIMIT  = 15'd13107;
    localparam logic [15:0] WORD_MAX    = 16'hFFFF;

    localparam logic        REG_SOUND_ENABLE = 1'b0;

    typedef struct packed {
        logic signed [15:0] frequency_hz;
        logic signed [15:0] duration_units;
    } request_t;

    typedef struct packed {
        logic        request_ok;
        logic        event_valid;
        logic [15:0] timer_divisor;
        logic [15:0] tick_count;
        logic        is_tone;
    } result_t;

    typedef struct packed {
        logic        ok;
        logic        evt;
        logic        rest;
        logic        sat;
        logic [14:0] freq;
        logic [14:0] rem;
        logic [15:0] quo;
        logic [15:0] ticks;
    } stage_t;

endpackage

[hw/rtl/tone_request_to_timer_event.sv]
// Top level: config register, divider pipeline and result stage.
//
//  port group   direction  handshake                  payload
//  request      in         start (busy always low)    req : request_t
//  result       out        done, one-cycle strobe     result : result_t
//  config       in/out     psel/penable/pwrite        pwdata[0] sound_enable
//
// Each request passes from start to done through one front stage, sixteen
// restoring divide stages (one quotient bit each) and one result stage.
// A new request is taken every cycle; busy never rises.
// Reset sets sound_enable to 1 and empties the pipeline valid bits.
// The result side cannot stall, so nothing is ever held back.
module tone_request_to_timer_event (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  trte_pkg::request_t req,
    output logic               done,
    output trte_pkg::result_t  result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic              sound_enable_reg;
    logic              done_reg;
    trte_pkg::result_t result_reg;
    trte_pkg::result_t result_next;
    logic              take;
    logic              cfg_write;
    logic              stg_valid [0:trte_pkg::DIV_STEPS];
    trte_pkg::stage_t  stg       [0:trte_pkg::DIV_STEPS];
    trte_pkg::stage_t  last;

    assign busy      = 1'b0;
    assign take      = start && !busy;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            trte_pkg::REG_SOUND_ENABLE: prdata = {31'd0, sound_enable_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_enable_reg <= 1'b1;
        end
        else if (cfg_write && (paddr[2] == trte_pkg::REG_SOUND_ENABLE))
        begin
            sound_enable_reg <= pwdata[0];
        end
    end

    trte_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .req          (req),
        .sound_enable (sound_enable_reg),
        .valid        (stg_valid[0]),
        .stage        (stg[0])
    );

    for (genvar k = 0; k < trte_pkg::DIV_STEPS; k++)
    begin : g_step
        trte_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[k]),
            .in_stage  (stg[k]),
            .dbit      (trte_pkg::DIVIDEND_LO[trte_pkg::DIV_STEPS - 1 - k]),
            .out_valid (stg_valid[k + 1]),
            .out_stage (stg[k + 1])
        );
    end

    assign last = stg[trte_pkg::DIV_STEPS];

    always_comb
    begin
        result_next.request_ok  = last.ok;
        result_next.event_valid = last.evt;
        result_next.is_tone     = last.evt && !last.rest;
        result_next.tick_count  = last.evt ? last.ticks : 16'd0;
        if (!last.evt || last.rest)
        begin
            result_next.timer_divisor = 16'd0;
        end
        else if (last.sat)
        begin
            result_next.timer_divisor = trte_pkg::WORD_MAX;
        end
        else if (last.quo == 16'd0)
        begin
            result_next.timer_divisor = 16'd1;
        end
        else
        begin
            result_next.timer_divisor = last.quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stg_valid[trte_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`include "assert_macros.svh"

    `ASSERT_DELAY(a_latency, clk, rst_n, take, 18, done, "request did not complete on time")
    `ASSERT_IMPLY(a_reject_no_event, clk, rst_n,
        done && !result.request_ok, !result.event_valid,
        "rejected request carries an event")
    `ASSERT_IMPLY(a_no_event_zero, clk, rst_n,
        done && !result.event_valid,
        (result.timer_divisor == 16'd0) && (result.tick_count == 16'd0) && !result.is_tone,
        "result without event has nonzero fields")
    `ASSERT_IMPLY(a_tone_flag, clk, rst_n,
        done && result.event_valid, result.is_tone == (result.timer_divisor != 16'd0),
        "tone flag disagrees with divisor")

endmodule

[hw/rtl/trte_front.sv]
// Front stage: classify the request, work out ticks, seed the divider.
module trte_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  trte_pkg::request_t req,
    input  logic               sound_enable,
    output logic               valid,
    output trte_pkg::stage_t   stage
);

    logic               valid_reg;
    trte_pkg::stage_t   stage_reg;
    trte_pkg::stage_t   stage_next;
    logic [14:0]        dur;
    logic [15:0]        dur_x4;
    logic [15:0]        dur_x5;

    assign dur    = req.duration_units[14:0];
    assign dur_x4 = {dur[13:0], 2'b00};
    assign dur_x5 = dur_x4 + {1'b0, dur};

    always_comb
    begin
        stage_next.ok   = !sound_enable || !req.frequency_hz[15];
        stage_next.evt  = sound_enable && !req.frequency_hz[15];
        stage_next.freq = req.frequency_hz[14:0];
        stage_next.rest = (req.frequency_hz[14:0] == 15'd0);
        stage_next.sat  = (req.frequency_hz[14:0] <= trte_pkg::SAT_FREQ);
        stage_next.rem  = trte_pkg::DIVIDEND_HI;
        stage_next.quo  = 16'd0;
        if (req.duration_units[15] || (dur == 15'd0))
        begin
            stage_next.ticks = 16'd1;
        end
        else if (dur > trte_pkg::TICK_LIMIT)
        begin
            stage_next.ticks = trte_pkg::WORD_MAX;
        end
        else
        begin
            stage_next.ticks = dur_x5;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

[hw/rtl/trte_div_step.sv]
// One restoring division step: produce one quotient bit per stage.
module trte_div_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  trte_pkg::stage_t in_stage,
    input  logic             dbit,
    output logic             out_valid,
    output trte_pkg::stage_t out_stage
);

    logic             valid_reg;
    trte_pkg::stage_t stage_reg;
    trte_pkg::stage_t stage_next;
    logic [15:0]      trial;
    logic [16:0]      diff;

    assign trial = {in_stage.rem, dbit};
    assign diff  = {1'b0, trial} - {2'b00, in_stage.freq};

    always_comb
    begin
        stage_next = in_stage;
        // Keep the remainder when the subtraction would go negative.
        if (diff[16])
        begin
            stage_next.rem = trial[14:0];
            stage_next.quo = {in_stage.quo[14:0], 1'b0};
        end
        else
        begin
            stage_next.rem = diff[14:0];
            stage_next.quo = {in_stage.quo[14:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

[bench/tone_scoreboard.sv]
`timescale 1ns / 100ps
// Scoreboard that predicts timer events from tone requests and checks the block's results.
class tone_scoreboard;
    localparam int PIT_CLOCK_HZ = 1193181;

    bit                sound_en;
    trte_pkg::result_t pending_results[$];
    int unsigned       fault_count;

    function new();
        sound_en = 1'b1;
        fault_count = 0;
    endfunction

    // Writes to indexes past the register list have no effect.
    function void write_reg(int unsigned index, logic [31:0] data);
        if (index == 32'(trte_pkg::REG_SOUND_ENABLE))
            sound_en = data[0];
    endfunction

    function trte_pkg::result_t predict_event(trte_pkg::request_t r);
        trte_pkg::result_t res;
        int                freq;
        int                dur;
        int                divisor;
        int                ticks;
        res = '0;
        freq = int'(r.frequency_hz);
        dur = int'(r.duration_units);
        // Sound off: accept silently.
        if (!sound_en)
        begin
            res.request_ok = 1'b1;
            return res;
        end
        // Negative frequency: reject, all fields zero.
        if (freq < 0)
            return res;
        if (freq == 0)
            divisor = 0;
        else
        begin
            divisor = PIT_CLOCK_HZ / freq;
            if (divisor > int'(trte_pkg::WORD_MAX))
                divisor = int'(trte_pkg::WORD_MAX);
            if (divisor == 0)
                divisor = 1;
        end
        if (dur <= 0)
            ticks = 1;
        else if (dur > int'(trte_pkg::TICK_LIMIT))
            ticks = int'(trte_pkg::WORD_MAX);
        else
            ticks = dur * 5;
        res.request_ok = 1'b1;
        res.event_valid = 1'b1;
        res.timer_divisor = 16'(divisor);
        res.tick_count = 16'(ticks);
        res.is_tone = (divisor != 0);
        return res;
    endfunction

    function void note_request(trte_pkg::request_t r);
        pending_results.push_back(predict_event(r));
    endfunction

    function int unsigned pending();
        return pending_results.size();
    endfunction

    function void check_result(trte_pkg::result_t got);
        trte_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("unexpected result: ok=%0b evt=%0b div=%0d ticks=%0d tone=%0b",
                         got.request_ok, got.event_valid, got.timer_divisor,
                         got.tick_count, got.is_tone);
            return;
        end
        want = pending_results.pop_front();
        if (got.request_ok !== want.request_ok || got.event_valid !== want.event_valid ||
            got.timer_divisor !== want.timer_divisor || got.tick_count !== want.tick_count ||
            got.is_tone !== want.is_tone)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("mismatch: want ok=%0b evt=%0b div=%0d ticks=%0d tone=%0b,",
                         want.request_ok, want.event_valid, want.timer_divisor,
                         want.tick_count, want.is_tone,
                         " got ok=%0b evt=%0b div=%0d ticks=%0d tone=%0b",
                         got.request_ok, got.event_valid,
                         got.timer_divisor, got.tick_count, got.is_tone);
        end
    endfunction

    function bit clean();
        return fault_count == 0 && pending_results.size() == 0;
    endfunction
endclass

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Top-level testbench for the tone request to timer event block.
module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned REG_UNMAPPED = 1;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    trte_pkg::request_t req = '0;
    logic               done;
    trte_pkg::result_t  result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    tone_scoreboard sb;

    tone_request_to_timer_event dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    initial
    begin
        int unsigned cycle_count;
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic trte_pkg::request_t make_request(int freq, int dur);
        trte_pkg::request_t r;
        r.frequency_hz = 16'(freq);
        r.duration_units = 16'(dur);
        return r;
    endfunction

    function automatic trte_pkg::request_t random_request();
        int freq;
        int dur;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: freq = int'($urandom_range(0, 65535)) - 32768;
            4, 5:       freq = $urandom_range(0, 40);
            6:          freq = -int'($urandom_range(1, 32768));
            7:
            begin
                case ($urandom_range(0, 5))
                    0: freq = 0;
                    1: freq = $urandom_range(17, 19);
                    2: freq = $urandom_range(36, 37);
                    3: freq = 32767;
                    4: freq = -1;
                    default: freq = -32768;
                endcase
            end
            default:    freq = $urandom_range(40, 2000);
        endcase
        case ($urandom_range(0, 3))
            0: dur = int'($urandom_range(0, 65535)) - 32768;
            1: dur = $urandom_range(13100, 13115);
            2: dur = int'($urandom_range(0, 6)) - 3;
            default: dur = $urandom_range(1, 200);
        endcase
        return make_request(freq, dur);
    endfunction

    // Call at a rising edge; returns at the edge that took the request.
    task automatic push_request(input trte_pkg::request_t r);
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(r);
    endtask

    // Drop start only for a real gap, so a burst keeps it high without a glitch.
    task automatic pause(input int unsigned n);
        if (n == 0)
            return;
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic reg_write(input int unsigned index, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(index * 4);
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(index, data);
    endtask

    task automatic directed(input int freq, input int dur);
        push_request(make_request(freq, dur));
        pause($urandom_range(0, 3));
    endtask

    task automatic set_sound(input bit en);
        logic [31:0] data;
        data = $urandom;
        data[0] = en;
        reg_write(32'(trte_pkg::REG_SOUND_ENABLE), data);
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned sent;
        int unsigned burst;
        int unsigned i;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 12);
            if (burst > n - sent)
                burst = n - sent;
            for (i = 0; i < burst; i++)
                push_request(random_request());
            sent += burst;
            // Now and then hold off until the pipeline is empty.
            if ($urandom_range(0, 39) == 0)
                drain();
            else if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 25));
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sound on from reset: rests, saturation, divisor and tick extremes.
        directed(0, 0);
        directed(0, 13107);
        directed(1, 1);
        directed(17, 100);
        directed(18, 13108);
        directed(19, -1);
        directed(36, 32767);
        directed(37, -32768);
        directed(440, 20);
        directed(1000, 13106);
        directed(32767, 32767);
        directed(-1, 10);
        directed(-32768, 0);
        directed(16384, 1);
        drain();

        // A write past the register list must not disturb sound_enable.
        reg_write(REG_UNMAPPED, 32'h0);
        directed(440, 5);
        directed(-7, 5);
        drain();

        // Sound off: every request accepted silently.
        set_sound(1'b0);
        directed(440, 10);
        directed(-5, 10);
        directed(0, 0);
        directed(32767, -32768);
        drain();

        set_sound(1'b1);
        run_random(500);
        set_sound(1'b0);
        run_random(150);
        set_sound(1'b1);
        run_random(500);
        set_sound(1'b1);
        run_random(400);
        set_sound(1'b0);
        run_random(100);
        set_sound(1'b1);
        run_random(250);

        repeat (trte_pkg::LATENCY + 4) @(posedge clk);
        if (sb.clean())
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/trte_pkg.sv
hw/rtl/trte_front.sv
hw/rtl/trte_div_step.sv
hw/rtl/tone_request_to_timer_event.sv
bench/tone_scoreboard.sv
bench/tb_top.sv
